// File: rtl/mrcs_pkg.sv
package mrcs_pkg;

	typedef enum logic [1:0] {
		CH_IDLE      = 2'd0,
		CH_BUSY_LOW  = 2'd1,
		CH_BUSY_HIGH = 2'd2,
		CH_COLLISION = 2'd3
	} chan_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_HIGH_HIGH = 2'd1,
		ERR_LOW_LOW   = 2'd2
	} dec_err_t;

	localparam int HALF_W    = 16;
	localparam int LIMIT_W   = 24;
	localparam int CFG_IDX_W = 2;
	localparam int BYTE_W    = 8;
	localparam int HALVES_PER_BYTE = 2 * BYTE_W;
	localparam int HIDX_W    = $clog2(HALVES_PER_BYTE);

	localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLLISION_TICKS = 2'd2;

	localparam logic [HALF_W-1:0]  RST_HALF_BIT_TICKS  = 16'd8000;
	localparam logic [LIMIT_W-1:0] RST_IDLE_TICKS      = 24'd17600;
	localparam logic [LIMIT_W-1:0] RST_COLLISION_TICKS = 24'd17600;

	typedef struct packed {
		logic  level_edge;
		logic  timeout_fire;
		logic  msg_end;
		chan_t chan_next;
	} line_status_t;

endpackage

// File: rtl/mrcs_line.sv
module mrcs_line
	import mrcs_pkg::*;
#(
	parameter int TIMEOUT_WIDTH = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                level,
	input  logic [LIMIT_W-1:0]  idle_ticks,
	input  logic [LIMIT_W-1:0]  collision_ticks,
	output line_status_t        status
);

	chan_t                    chan_q, chan_d;
	logic                     last_level_q;
	logic [TIMEOUT_WIDTH-1:0] tmo_cnt_q, tmo_cnt_d, tmo_inc, tmo_limit;
	logic                     tmo_run_q, tmo_run_d;
	logic                     lvl_edge, fire;
	logic [31:0]              limit_wide;

	assign lvl_edge   = level != last_level_q;
	// limit is masked to the counter width
	assign limit_wide = {{(32-LIMIT_W){1'b0}},
		(chan_q == CH_BUSY_HIGH) ? idle_ticks : collision_ticks};
	assign tmo_limit  = limit_wide[TIMEOUT_WIDTH-1:0];
	// saturate at full scale
	assign tmo_inc    = (tmo_cnt_q != '1) ? tmo_cnt_q + 1'b1 : tmo_cnt_q;

	// next state
	always_comb begin
		chan_d    = chan_q;
		tmo_cnt_d = tmo_cnt_q;
		tmo_run_d = tmo_run_q;
		fire      = 1'b0;
		if (lvl_edge) begin
			unique case (chan_q) inside
				CH_IDLE, CH_BUSY_HIGH: chan_d = CH_BUSY_LOW;
				default:               chan_d = CH_BUSY_HIGH;
			endcase
			tmo_cnt_d = '0;
			tmo_run_d = 1'b1;
		end else if (tmo_run_q) begin
			tmo_cnt_d = tmo_inc;
			if (tmo_inc >= tmo_limit) begin
				fire      = 1'b1;
				chan_d    = level ? CH_IDLE : CH_COLLISION;
				tmo_run_d = 1'b0;
			end
		end
	end

	// outputs
	always_comb begin
		status.level_edge   = lvl_edge;
		status.timeout_fire = fire;
		status.msg_end      = fire & level;
		status.chan_next    = chan_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q       <= CH_IDLE;
			last_level_q <= 1'b1;
			tmo_cnt_q    <= '0;
			tmo_run_q    <= 1'b0;
		end else if (advance) begin
			chan_q       <= chan_d;
			last_level_q <= level;
			tmo_cnt_q    <= tmo_cnt_d;
			tmo_run_q    <= tmo_run_d;
		end
	end

endmodule

// File: rtl/mrcs_decode.sv
module mrcs_decode
	import mrcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              level,
	input  logic [HALF_W-1:0] half_bit_ticks,
	input  line_status_t      status,
	output logic              byte_valid,
	output logic [BYTE_W-1:0] data_byte,
	output dec_err_t          decode_error
);

	logic [HALF_W-1:0] phase_q, phase_d, phase_inc;
	logic [HIDX_W-1:0] hidx_q, hidx_d;
	logic              first_q, first_d;
	logic [BYTE_W-1:0] shift_q, shift_d;
	logic              sample, busy;

	assign phase_inc = phase_q + 1'b1;
	assign busy      = (status.chan_next == CH_BUSY_LOW) || (status.chan_next == CH_BUSY_HIGH);

	always_comb begin
		phase_d = phase_q;
		sample  = 1'b0;
		if (status.level_edge) begin
			phase_d = half_bit_ticks >> 1;
		end else if (phase_inc >= half_bit_ticks) begin
			phase_d = '0;
			sample  = 1'b1;
		end else begin
			phase_d = phase_inc;
		end
	end

	always_comb begin
		hidx_d       = hidx_q;
		first_d      = first_q;
		shift_d      = shift_q;
		byte_valid   = 1'b0;
		data_byte    = '0;
		decode_error = ERR_NONE;
		if (status.timeout_fire) begin
			hidx_d  = HIDX_W'(1);
			first_d = 1'b1;
		end
		// a fired timeout never leaves the channel busy, so no sample then
		if (sample && busy) begin
			if (!hidx_q[0]) begin
				first_d = level;
				hidx_d  = hidx_q + 1'b1;
			end else if (first_q == level) begin
				decode_error = level ? ERR_HIGH_HIGH : ERR_LOW_LOW;
			end else begin
				shift_d = {shift_q[BYTE_W-2:0], level};
				hidx_d  = hidx_q + 1'b1;
				if (hidx_q == HIDX_W'(HALVES_PER_BYTE - 1)) begin
					byte_valid = 1'b1;
					data_byte  = shift_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			hidx_q  <= HIDX_W'(1);
			first_q <= 1'b1;
			shift_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			first_q <= first_d;
			shift_q <= shift_d;
		end
	end

endmodule

// File: rtl/manchester_receiver_carrier_sense.sv
// Manchester receiver with carrier sense. Each input item is one sample of the
// receive line (one tick). Every item yields exactly one result item carrying
// the channel state after that tick (idle, busy low, busy high, collision), a
// completed byte strobe with its data (MSB first, '10' decodes to 0, '01' to 1),
// the end-of-message flag raised when a high line times out to idle, and a
// decode error code for a high-high or low-low pair. For each item,
// the line tracker and the pair decoder update their state in the cycle the
// item is accepted and the result is held in an output register, so one item
// is accepted every cycle while the result side keeps up, and the input stalls
// only while a result waits untaken. Registers: 0 half_bit_ticks, 1 idle_ticks,
// 2 collision_ticks; write them only while the block is idle. cfg_ready is
// always high. TIMEOUT_WIDTH sets the width of the saturating edge timeout
// counter; the timeout limits are masked to that width.
module manchester_receiver_carrier_sense
	import mrcs_pkg::*;
#(
	parameter int TIMEOUT_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// sample channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 rx_level,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           channel_state,
	output logic                 byte_valid,
	output logic [BYTE_W-1:0]    data_byte,
	output logic                 message_end,
	output logic [1:0]           decode_error,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data
);

	logic [HALF_W-1:0]  half_bit_ticks_q;
	logic [LIMIT_W-1:0] idle_ticks_q;
	logic [LIMIT_W-1:0] collision_ticks_q;

	logic               advance;
	line_status_t       status;
	logic               dec_valid;
	logic [BYTE_W-1:0]  dec_byte;
	dec_err_t           dec_err;

	logic               out_valid_q;
	logic [1:0]         chan_q;
	logic               byte_valid_q;
	logic [BYTE_W-1:0]  data_byte_q;
	logic               msg_end_q;
	logic [1:0]         err_q;

	// accept a sample whenever the output register is empty or being drained
	assign in_ready  = !out_valid_q || out_ready;
	assign advance   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// configuration registers; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_ticks_q  <= RST_HALF_BIT_TICKS;
			idle_ticks_q      <= RST_IDLE_TICKS;
			collision_ticks_q <= RST_COLLISION_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HALF_BIT_TICKS:  half_bit_ticks_q  <= cfg_data[HALF_W-1:0];
				REG_IDLE_TICKS:      idle_ticks_q      <= cfg_data;
				REG_COLLISION_TICKS: collision_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// line level tracking, edge detect and timeout
	mrcs_line #(
		.TIMEOUT_WIDTH(TIMEOUT_WIDTH)
	) u_line (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.level          (rx_level),
		.idle_ticks     (idle_ticks_q),
		.collision_ticks(collision_ticks_q),
		.status         (status)
	);

	// half-bit phase, pairing and byte assembly
	mrcs_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.level         (rx_level),
		.half_bit_ticks(half_bit_ticks_q),
		.status        (status),
		.byte_valid    (dec_valid),
		.data_byte     (dec_byte),
		.decode_error  (dec_err)
	);

	// result register: load on accept, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			chan_q       <= status.chan_next;
			byte_valid_q <= dec_valid;
			data_byte_q  <= dec_byte;
			msg_end_q    <= status.msg_end;
			err_q        <= dec_err;
		end
	end

	assign out_valid     = out_valid_q;
	assign channel_state = chan_q;
	assign byte_valid    = byte_valid_q;
	assign data_byte     = data_byte_q;
	assign message_end   = msg_end_q;
	assign decode_error  = err_q;

endmodule
